### sv/bds_pkg.sv
// Shared types and constants for the band dead-zone smoother.
`default_nettype none

package bds_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 10;
    localparam int BAND_OUT_W = 3;
    localparam int DZ_W       = 10;
    localparam int SMOOTH_W   = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // Quotient bits kept by the divider; anything larger saturates anyway
    localparam int QUOT_W = 11;
    localparam int CNT_W  = 4;
    // Blend accumulator: 256 * 1023 fits in 18 bits
    localparam int ACC_W  = 18;

    localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 9'd256;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
    } bds_in_t;

    typedef struct packed {
        logic [BAND_OUT_W-1:0] band;
        logic [LEVEL_W-1:0]    level;
        logic                  last_band;
    } bds_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULS,
        ST_CHK,
        ST_DIV,
        ST_MULA,
        ST_MULB,
        ST_WRITE
    } bds_state_t;

endpackage

`default_nettype wire

### sv/band_deadzone_smoother_top.sv
// Band dead-zone smoother: per-band rescale and exponential smoothing.
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_ready        bds_in_t  (sample, frame_start)
//  result    out        result_valid / result_ready    bds_out_t (band, level, last_band)
//  cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// A sample above the dead zone passes from acceptance to the output register
// through one product, one range check, 11 restoring divide steps, two blend
// products and the write-back, all through one shared multiplier and one
// subtractor. A quotient too wide for the divider saturates after the range
// check and skips the divide steps; a silent sample, or any sample while the dead zone
// sits at full scale, skips the divider.
// item_ready is high only while the sequencer idles; a result waiting in the
// output register stalls the write-back, and with it the acceptance of the next sample.
// Reset clears the band counter, the stored levels and both registers.
`default_nettype none

module band_deadzone_smoother_top #(
    parameter int BANDS   = 7,
    parameter int ADC_MAX = 1023
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire bds_pkg::bds_in_t               item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output bds_pkg::bds_out_t                   result,
    input  wire logic                           cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int AW  = $clog2(ADC_MAX + 1);
    localparam int OW  = (AW > bds_pkg::LEVEL_W) ? AW : bds_pkg::LEVEL_W;
    localparam int PW  = 2 * OW;
    localparam int RW  = AW + bds_pkg::QUOT_W;
    localparam int SAT = (ADC_MAX < 1023) ? ADC_MAX : 1023;

    bds_pkg::bds_state_t state_reg, state_next;

    logic [BW-1:0]                     counter_reg, counter_next;
    logic [BW-1:0]                     band_reg, band_next;
    logic [bds_pkg::SAMPLE_W-1:0]      sample_reg, sample_next;
    logic [RW-1:0]                     rem_reg, rem_next;
    logic [RW-1:0]                     dsh_reg, dsh_next;
    logic [bds_pkg::QUOT_W-1:0]        quot_reg, quot_next;
    logic [bds_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bds_pkg::LEVEL_W-1:0]       v_reg, v_next;
    logic [bds_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [bds_pkg::DZ_W-1:0]          dead_zone_reg;
    logic [bds_pkg::SMOOTH_W-1:0]      smoothing_reg;
    logic [bds_pkg::LEVEL_W-1:0]       levels_reg [BANDS];
    bds_pkg::bds_out_t                 result_reg, result_next;
    logic                              result_valid_reg, result_valid_next;

    logic [bds_pkg::SMOOTH_W-1:0]      alpha;
    logic [AW-1:0]                     divisor;
    logic                              silent;
    logic                              clipped;
    logic [OW-1:0]                     mul_a, mul_b;
    logic [PW-1:0]                     product;
    logic                              rem_ge;
    logic [RW-1:0]                     rem_sub;
    logic [bds_pkg::QUOT_W-1:0]        quot_step;
    logic                              level_we;
    logic [bds_pkg::LEVEL_W-1:0]       level_new;
    logic                              last;

    assign alpha   = (smoothing_reg > bds_pkg::SMOOTH_ONE) ? bds_pkg::SMOOTH_ONE
                                                           : smoothing_reg;
    assign divisor = AW'(ADC_MAX) - AW'(dead_zone_reg);
    assign silent  = (sample_reg <= dead_zone_reg);
    assign clipped = (OW'(dead_zone_reg) >= OW'(ADC_MAX));

    // Shared multiplier: numerator, then the two blend terms
    always_comb
    begin
        unique case (state_reg)
            bds_pkg::ST_MULA:
            begin
                mul_a = OW'(alpha);
                mul_b = OW'(levels_reg[band_reg]);
            end
            bds_pkg::ST_MULB:
            begin
                mul_a = OW'(bds_pkg::SMOOTH_ONE - alpha);
                mul_b = OW'(v_reg);
            end
            default:
            begin
                mul_a = OW'(sample_reg - dead_zone_reg);
                mul_b = OW'(ADC_MAX);
            end
        endcase
    end

    assign product   = mul_a * mul_b;
    assign rem_ge    = (rem_reg >= dsh_reg);
    assign rem_sub   = rem_reg - dsh_reg;
    assign quot_step = {quot_reg[bds_pkg::QUOT_W-2:0], rem_ge};
    assign level_new = acc_reg[bds_pkg::ACC_W-1 -: bds_pkg::LEVEL_W];
    assign last      = (band_reg == BW'(BANDS - 1));

    always_comb
    begin
        state_next        = state_reg;
        counter_next      = counter_reg;
        band_next         = band_reg;
        sample_next       = sample_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        quot_next         = quot_reg;
        cnt_next          = cnt_reg;
        v_next            = v_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        level_we          = 1'b0;
        item_ready        = 1'b0;

        unique case (state_reg)
            bds_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    band_next   = item.frame_start ? '0 : counter_reg;
                    sample_next = item.sample;
                    state_next  = bds_pkg::ST_MULS;
                end
            end
            bds_pkg::ST_MULS:
            begin
                rem_next = RW'(product);
                if (silent)
                begin
                    v_next     = '0;
                    state_next = bds_pkg::ST_MULA;
                end
                else if (clipped)
                begin
                    v_next     = bds_pkg::LEVEL_W'(SAT);
                    state_next = bds_pkg::ST_MULA;
                end
                else
                begin
                    state_next = bds_pkg::ST_CHK;
                end
            end
            bds_pkg::ST_CHK:
            begin
                // Quotient too wide for the divider: saturate straight away
                if (rem_reg >= (RW'(divisor) << bds_pkg::QUOT_W))
                begin
                    v_next     = bds_pkg::LEVEL_W'(SAT);
                    state_next = bds_pkg::ST_MULA;
                end
                else
                begin
                    dsh_next   = RW'(divisor) << (bds_pkg::QUOT_W - 1);
                    quot_next  = '0;
                    cnt_next   = bds_pkg::CNT_W'(bds_pkg::QUOT_W - 1);
                    state_next = bds_pkg::ST_DIV;
                end
            end
            bds_pkg::ST_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_sub;
                end
                quot_next = quot_step;
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    v_next     = (quot_step > bds_pkg::QUOT_W'(SAT))
                                 ? bds_pkg::LEVEL_W'(SAT)
                                 : quot_step[bds_pkg::LEVEL_W-1:0];
                    state_next = bds_pkg::ST_MULA;
                end
            end
            bds_pkg::ST_MULA:
            begin
                acc_next   = bds_pkg::ACC_W'(product);
                state_next = bds_pkg::ST_MULB;
            end
            bds_pkg::ST_MULB:
            begin
                acc_next   = acc_reg + bds_pkg::ACC_W'(product);
                state_next = bds_pkg::ST_WRITE;
            end
            bds_pkg::ST_WRITE:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    level_we              = 1'b1;
                    result_next.band      = bds_pkg::BAND_OUT_W'(band_reg);
                    result_next.level     = level_new;
                    result_next.last_band = last;
                    result_valid_next     = 1'b1;
                    counter_next          = last ? '0 : band_reg + BW'(1);
                    state_next            = bds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bds_pkg::ST_IDLE;
            counter_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            counter_reg      <= counter_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg   <= band_next;
        sample_reg <= sample_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        v_reg      <= v_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANDS; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else if (level_we)
        begin
            levels_reg[band_reg] <= level_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= '0;
            smoothing_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bds_pkg::REG_DEAD_ZONE: dead_zone_reg <= cfg_data;
                bds_pkg::REG_SMOOTHING: smoothing_reg <= cfg_data[bds_pkg::SMOOTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == bds_pkg::ST_WRITE))
        else $error("result raised outside write-back");

    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg <= BW'(BANDS - 1))
        else $error("band counter out of range");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bds_pkg::ST_DIV |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder exceeds bound");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == bds_pkg::ST_MULS))
        else $error("accepted request did not start the sequencer");
`endif

endmodule

`default_nettype wire

### sim/band_deadzone_smoother_top_test.sv
// Self-checking testbench for the band dead-zone smoother top level.
`timescale 1ns / 100ps

module band_deadzone_smoother_top_test;

    localparam int BAND_TOTAL = 7;
    localparam int FULL_SCALE = 1023;
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 195;
    localparam int SETTLE     = 20;

    // Predicts each band's smoothed level and holds the expected results in order.
    class level_scoreboard;
        bds_pkg::bds_out_t                 expected_q[$];
        logic [bds_pkg::DZ_W-1:0]          dead_zone;
        logic [bds_pkg::SMOOTH_W-1:0]      smoothing;
        int unsigned                       next_band;
        logic [bds_pkg::LEVEL_W-1:0]       levels[BAND_TOTAL];
        int                                requests;
        int                                results;
        int                                mismatches;

        function new();
            dead_zone  = '0;
            smoothing  = '0;
            next_band  = 0;
            requests   = 0;
            results    = 0;
            mismatches = 0;
            foreach (levels[i])
                levels[i] = '0;
        endfunction

        function void write_register(logic [bds_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bds_pkg::CFG_DATA_W-1:0] data);
            if (idx == bds_pkg::REG_DEAD_ZONE)
                dead_zone = data[bds_pkg::DZ_W-1:0];
            else if (idx == bds_pkg::REG_SMOOTHING)
                smoothing = data[bds_pkg::SMOOTH_W-1:0];
        endfunction

        function int unsigned rescaled(logic [bds_pkg::SAMPLE_W-1:0] s);
            int unsigned sv;
            int unsigned dz;
            int unsigned v;
            sv = s;
            dz = dead_zone;
            if (sv <= dz)
                return 0;
            if (dz >= FULL_SCALE)
                v = FULL_SCALE;
            else
            begin
                v = ((sv - dz) * FULL_SCALE) / (FULL_SCALE - dz);
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
            end
            if (v > 1023)
                v = 1023;
            return v;
        endfunction

        function void note_request(bds_pkg::bds_in_t req);
            int unsigned       band;
            int unsigned       a;
            int unsigned       old;
            int unsigned       acc;
            bds_pkg::bds_out_t want;
            band = req.frame_start ? 0 : next_band;
            if (band >= BAND_TOTAL)
                band = 0;
            // Weights above one saturate, so the old level holds
            a   = (smoothing > 256) ? 256 : smoothing;
            old = levels[band];
            acc = (a * old + (256 - a) * rescaled(req.sample)) >> 8;
            levels[band]   = acc[bds_pkg::LEVEL_W-1:0];
            want.band      = band[bds_pkg::BAND_OUT_W-1:0];
            want.level     = acc[bds_pkg::LEVEL_W-1:0];
            want.last_band = (band + 1 == BAND_TOTAL);
            next_band      = want.last_band ? 0 : band + 1;
            expected_q.push_back(want);
            requests++;
        endfunction

        function void check_result(bds_pkg::bds_out_t got);
            bds_pkg::bds_out_t want;
            results++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: band %0d level %0d last %0b",
                             got.band, got.level, got.last_band);
                return;
            end
            want = expected_q.pop_front();
            if (got.band !== want.band || got.level !== want.level
                || got.last_band !== want.last_band)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch at result %0d: expected band %0d level %0d last %0b,",
                              " got band %0d level %0d last %0b"},
                             results, want.band, want.level, want.last_band,
                             got.band, got.level, got.last_band);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_ready;
    bds_pkg::bds_in_t               item;
    logic                           result_valid;
    logic                           result_ready;
    bds_pkg::bds_out_t              result;
    logic                           cfg_we;
    logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bds_pkg::CFG_DATA_W-1:0] cfg_data;

    level_scoreboard sb;
    bit              calm;
    int              settings_used;

    band_deadzone_smoother_top #(
        .BANDS   (BAND_TOTAL),
        .ADC_MAX (FULL_SCALE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Timed out with %0d results still expected", sb.expected_q.size());
        $display("** band_deadzone_smoother_top: FAILED **");
        $finish;
    end

    // Both handshakes are sampled before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_request(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // Result side back-pressure
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send_request(input logic [bds_pkg::SAMPLE_W-1:0] s, input logic fs);
        bds_pkg::bds_in_t req;
        req.sample      = s;
        req.frame_start = fs;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Write both registers back to back, then drop the enable
    task automatic apply_settings(input logic [bds_pkg::CFG_DATA_W-1:0] dz,
                                  input logic [bds_pkg::CFG_DATA_W-1:0] sm);
        cfg_we    <= 1'b1;
        cfg_index <= bds_pkg::REG_DEAD_ZONE;
        cfg_data  <= dz;
        sb.write_register(bds_pkg::REG_DEAD_ZONE, dz);
        @(posedge clk);
        cfg_index <= bds_pkg::REG_SMOOTHING;
        cfg_data  <= sm;
        sb.write_register(bds_pkg::REG_SMOOTHING, sm);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Close the phase and hold until every result is back
    task automatic drain;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0 || result_valid);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [bds_pkg::SAMPLE_W-1:0] pick_sample(
        logic [bds_pkg::DZ_W-1:0] dz);
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return bds_pkg::LEVEL_MAX;
            2: return dz + bds_pkg::SAMPLE_W'($urandom_range(0, 2))
                      - bds_pkg::SAMPLE_W'(1);
            default: return bds_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [bds_pkg::CFG_DATA_W-1:0] dz;
        logic [bds_pkg::CFG_DATA_W-1:0] sm;
        logic                           fs;
        int                             pos;
        sb            = new();
        calm          = 1'b0;
        settings_used = 0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = bds_pkg::REG_DEAD_ZONE;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, a frame start mid-frame and a wrap without one
        apply_settings(10'd0, 10'd0);
        send_request(10'd0, 1'b1);
        send_request(10'd1023, 1'b0);
        send_request(10'd512, 1'b0);
        send_request(10'd1, 1'b0);
        send_request(10'd1023, 1'b1);
        send_request(10'd300, 1'b0);
        send_request(10'd1022, 1'b0);
        send_request(10'd1023, 1'b0);
        send_request(10'd5, 1'b0);
        send_request(10'd800, 1'b0);
        send_request(10'd1023, 1'b0);
        send_request(10'd64, 1'b0);
        drain;

        // Weight beyond one: levels hold
        apply_settings(10'd1023, 10'd300);
        send_request(10'd1023, 1'b1);
        send_request(10'd0, 1'b0);
        send_request(10'd1022, 1'b0);
        drain;

        // Dead zone at full scale: nothing passes
        apply_settings(10'd1023, 10'd0);
        send_request(10'd1023, 1'b1);
        send_request(10'd1022, 1'b0);
        drain;

        // Samples either side of the dead zone
        apply_settings(10'd100, 10'd128);
        send_request(10'd100, 1'b1);
        send_request(10'd101, 1'b0);
        send_request(10'd99, 1'b0);
        send_request(10'd1023, 1'b0);
        send_request(10'd1023, 1'b0);
        drain;

        // Top bit of the write data is dropped for the weight
        apply_settings(10'd1022, 10'h3FF);
        send_request(10'd1023, 1'b1);
        send_request(10'd1022, 1'b0);
        drain;

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            unique case (p)
                0: begin dz = 10'd0;    sm = 10'd0;   end
                1: begin dz = 10'd1023; sm = bds_pkg::CFG_DATA_W'($urandom); end
                2: begin dz = bds_pkg::CFG_DATA_W'($urandom); sm = 10'd256; end
                3: begin dz = bds_pkg::CFG_DATA_W'($urandom_range(0, 300)); sm = 10'd255; end
                4: begin dz = 10'd1;    sm = 10'd1;   end
                default:
                begin
                    dz = bds_pkg::CFG_DATA_W'($urandom_range(0, 700));
                    sm = bds_pkg::CFG_DATA_W'($urandom);
                end
            endcase
            apply_settings(dz, sm);
            pos = 0;
            for (int i = 0; i < PHASE_REQS; i++)
            begin
                // Mostly whole frames; now and then a stray start or a missing one
                if (pos == 0)
                    fs = ($urandom_range(0, 7) != 0);
                else
                    fs = ($urandom_range(0, 15) == 0);
                if (fs)
                    pos = 0;
                pos = (pos + 1) % BAND_TOTAL;
                send_request(pick_sample(dz), fs);
            end
            drain;
        end

        $display("Sent %0d requests and checked %0d results over %0d register settings",
                 sb.requests, sb.results, settings_used);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("** band_deadzone_smoother_top: PASSED **");
        else
            $display("** band_deadzone_smoother_top: FAILED **");
        $finish;
    end

endmodule
